// ----- rtl/bdpa_pkg.sv -----
package bdpa_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_DIFF    = 3'd1,
    KIND_EXTRA   = 3'd2,
    KIND_OK      = 3'd3,
    KIND_SHORT   = 3'd4,
    KIND_RANGE   = 3'd5,
    KIND_IGNORED = 3'd6
  } kind_t;

  typedef enum logic [0:0] {
    REG_NEW_SIZE = 1'b0,
    REG_OLD_SIZE = 1'b1
  } reg_index_t;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned HEADER_COUNT_W = 5;

endpackage

// ----- rtl/binary_delta_patch_applier.sv -----
// Delta patch applier: takes the patch body one byte per request and produces
// the new file one byte per request.
// Input channel s_axis: tdata carries the patch byte and the old-file byte at
// the offset that the previous result reported in next_old_offset (the old
// byte matters only while diff bytes are being consumed).
// Output channel m_axis: exactly one result per input request; tuser carries
// the kind (header byte, diff, extra, done ok, done short, old range error,
// ignored), tdata the new byte, its new-file offset and the next old offset.
// Configuration channel cfg: index 0 writes the expected new size, index 1 the
// old-file size; write only while no request is in flight.
// A request's result is registered and shows in the cycle after it is accepted.
// Throughput is one request per clock while results are taken, set by the single
// result register that follows the per-byte add and the 65-bit seek adder.
// Reset (rst, synchronous) returns to the first header byte with all counters,
// offsets and both size registers at zero. When the receiver stalls, the
// result holds and s_axis_tready drops until the result is taken.
module binary_delta_patch_applier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [7:0] patch_byte, [15:8] old_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // [7:0] new_byte, [71:8] new_offset,
                                       // [135:72] next_old_offset
  output logic [2:0]   m_axis_tuser,   // [2:0] kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_DIFF   = 3'd1,
    PH_EXTRA  = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  localparam logic [bdpa_pkg::HEADER_COUNT_W-1:0] LAST_HEADER =
    bdpa_pkg::HEADER_COUNT_W'(bdpa_pkg::HEADER_BYTES - 1);

  phase_t                              phase, phase_next;
  logic [bdpa_pkg::HEADER_COUNT_W-1:0] header_count, header_count_next;
  logic [63:0] diff_left, diff_left_next;
  logic [63:0] extra_left, extra_left_next;
  logic [63:0] seek_amount, seek_amount_next;
  logic [63:0] old_position, old_position_next;
  logic [63:0] written_total, written_total_next;
  logic [63:0] new_size, old_size;

  logic [7:0]  patch_byte, old_byte;
  logic [63:0] seek_op;
  logic        seek_cin;
  logic [64:0] seek_sum;
  logic        seek_ok;
  logic [63:0] seek_pos;

  bdpa_pkg::kind_t kind;
  logic [7:0]  new_byte;
  logic [63:0] new_offset;

  logic        out_valid;
  bdpa_pkg::kind_t out_kind;
  logic [7:0]  out_byte;
  logic [63:0] out_offset;
  logic [63:0] out_old;

  logic        accept;

  assign patch_byte = s_axis_tdata[7:0];
  assign old_byte   = s_axis_tdata[15:8];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {out_old, out_offset, out_byte};

  // One adder serves every seek: in diff the old offset has just advanced,
  // so fold that increment in as the carry.
  always_comb begin
    seek_op  = (phase == PH_HEADER) ? {seek_amount[55:0], patch_byte} : seek_amount;
    seek_cin = (phase == PH_DIFF);
    seek_sum = {1'b0, old_position} + {1'b0, seek_op} + 65'(seek_cin);
    // Negative seek: carry out means no borrow. Positive: carry means saturate.
    seek_ok  = seek_op[63] ? seek_sum[64] : 1'b1;
    seek_pos = (!seek_op[63] && seek_sum[64]) ? '1 : seek_sum[63:0];
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    diff_left_next     = diff_left;
    extra_left_next    = extra_left;
    seek_amount_next   = seek_amount;
    old_position_next  = old_position;
    written_total_next = written_total;
    kind               = bdpa_pkg::KIND_IGNORED;
    new_byte           = 8'd0;

    case (phase)
      PH_HEADER: begin
        kind = bdpa_pkg::KIND_HEADER;
        case (header_count[4:3])
          2'd0:    diff_left_next  = {diff_left[55:0], patch_byte};
          2'd1:    extra_left_next = {extra_left[55:0], patch_byte};
          default: seek_amount_next = seek_op;
        endcase
        header_count_next = header_count + 1'b1;
        if (header_count == LAST_HEADER) begin
          header_count_next = '0;
          if (diff_left == '0 && extra_left == '0 && seek_op == '0) begin
            kind       = (written_total == new_size) ? bdpa_pkg::KIND_OK
                                                     : bdpa_pkg::KIND_SHORT;
            phase_next = PH_DONE;
          end else if (diff_left != '0) begin
            phase_next = PH_DIFF;
          end else if (extra_left != '0) begin
            phase_next = PH_EXTRA;
          end else if (seek_ok) begin
            old_position_next = seek_pos;
          end else begin
            kind       = bdpa_pkg::KIND_RANGE;
            phase_next = PH_ERROR;
          end
        end
      end
      PH_DIFF: begin
        if (old_position >= old_size) begin
          kind       = bdpa_pkg::KIND_RANGE;
          phase_next = PH_ERROR;
        end else begin
          kind               = bdpa_pkg::KIND_DIFF;
          new_byte           = patch_byte + old_byte;
          written_total_next = written_total + 64'd1;
          old_position_next  = old_position + 64'd1;
          diff_left_next     = diff_left - 64'd1;
          if (diff_left == 64'd1) begin
            if (extra_left != '0) begin
              phase_next = PH_EXTRA;
            end else if (seek_ok) begin
              old_position_next = seek_pos;
              phase_next        = PH_HEADER;
            end else begin
              kind       = bdpa_pkg::KIND_RANGE;
              phase_next = PH_ERROR;
            end
          end
        end
      end
      PH_EXTRA: begin
        kind               = bdpa_pkg::KIND_EXTRA;
        new_byte           = patch_byte;
        written_total_next = written_total + 64'd1;
        extra_left_next    = extra_left - 64'd1;
        if (extra_left == 64'd1) begin
          if (seek_ok) begin
            old_position_next = seek_pos;
            phase_next        = PH_HEADER;
          end else begin
            kind       = bdpa_pkg::KIND_RANGE;
            phase_next = PH_ERROR;
          end
        end
      end
      default: begin
        kind = bdpa_pkg::KIND_IGNORED;
      end
    endcase

    if (kind == bdpa_pkg::KIND_DIFF || kind == bdpa_pkg::KIND_EXTRA) begin
      new_offset = written_total;
    end else begin
      new_byte   = 8'd0;
      new_offset = written_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      diff_left     <= '0;
      extra_left    <= '0;
      seek_amount   <= '0;
      old_position  <= '0;
      written_total <= '0;
      new_size      <= '0;
      old_size      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdpa_pkg::REG_NEW_SIZE: new_size <= cfg_data;
          bdpa_pkg::REG_OLD_SIZE: old_size <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        header_count  <= header_count_next;
        diff_left     <= diff_left_next;
        extra_left    <= extra_left_next;
        seek_amount   <= seek_amount_next;
        old_position  <= old_position_next;
        written_total <= written_total_next;
        out_valid     <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind   <= kind;
      out_byte   <= new_byte;
      out_offset <= new_offset;
      out_old    <= old_position_next;
    end
  end

endmodule

// ----- rtl/bdpa_checker.sv -----
module bdpa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // Every accepted request shows a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // A stalled result must not be overwritten by a new request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // Only diff and extra results carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != bdpa_pkg::KIND_DIFF
      && m_axis_tuser != bdpa_pkg::KIND_EXTRA |-> m_axis_tdata[7:0] == 8'd0)
    else $error("non-data result carries a byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind binary_delta_patch_applier bdpa_checker u_bdpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
